FILE: src/dual_led_channel_startup_sequencer_assert.svh
// Assertion macros for the dual LED channel startup sequencer.
// Used by the top level; expect clk and rst_n in the including scope.
`ifndef DUAL_LED_CHANNEL_STARTUP_SEQUENCER_ASSERT_SVH
`define DUAL_LED_CHANNEL_STARTUP_SEQUENCER_ASSERT_SVH
`ifndef SYNTH
// Clocked check, inactive while reset is asserted
`define DLCSS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dlcss assertion failed");
// Condition that must never be true at a clock edge
`define DLCSS_ASSERT_NEVER(lbl, expr) `DLCSS_ASSERT(lbl, !(expr))
`else
`define DLCSS_ASSERT(lbl, prop)
`define DLCSS_ASSERT_NEVER(lbl, expr)
`endif
`endif

FILE: src/dlcss_pkg.sv
// Shared types and constants of the dual LED channel startup sequencer.
// No dependencies; used by dlcss_step and the top level.
package dlcss_pkg;

    // Sequencer modes
    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_SETTLE = 3'd1,
        MODE_BOTH   = 3'd2,
        MODE_CH1    = 3'd3,
        MODE_CH2    = 3'd4
    } mode_t;

    // Steps of one startup path
    typedef enum logic [1:0] {
        STEP_RELAY    = 2'd0,
        STEP_DRIVER   = 2'd1,
        STEP_REGULATE = 2'd2
    } step_t;

    // Protection codes
    typedef enum logic [1:0] {
        PROT_NONE      = 2'd0,
        PROT_ALL_OFF   = 2'd1,
        PROT_CH1_FAULT = 2'd2,
        PROT_CH2_FAULT = 2'd3
    } prot_t;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_ENABLED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PFC_SETTLE_MS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVER_DELAY_MS = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] PFC_SETTLE_RESET   = 16'd800;
    localparam logic [15:0] DRIVER_DELAY_RESET = 16'd200;
    localparam logic [15:0] TIMER_MAX          = 16'hFFFF;

    // Configuration registers
    typedef struct packed {
        logic        system_enabled;
        logic [15:0] pfc_settle_ms;
        logic [15:0] driver_delay_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        system_enabled:  1'b1,
        pfc_settle_ms:   PFC_SETTLE_RESET,
        driver_delay_ms: DRIVER_DELAY_RESET
    };

    // Input item, last field in the lowest bits
    typedef struct packed {
        logic       fault_two;
        logic       fault_one;
        logic       overtemp_shutdown;
        logic       upgrade_active;
        logic [9:0] elapsed_ms;
        logic [7:0] level_two;
        logic [7:0] level_one;
    } item_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [1:0] regulate_mask;
        logic [2:0] mode;
        logic       driver2_on;
        logic       driver1_on;
        logic       relay2_on;
        logic       relay1_on;
        logic       pfc_on;
        logic       ch2_off;
        logic       ch1_off;
        logic       all_off;
        logic [1:0] protection_code;
    } result_t;

    localparam int unsigned ITEM_W     = $bits(item_t);
    localparam int unsigned RESULT_W   = $bits(result_t);
    localparam int unsigned IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // Sequencer state carried from item to item
    typedef struct packed {
        mode_t       mode;
        logic        armed;
        logic [15:0] mode_timer;
        step_t       both_step;
        step_t       one_step;
        step_t       two_step;
        logic [15:0] tmr_both;
        logic [15:0] tmr_one;
        logic [15:0] tmr_two;
        logic [1:0]  regulate;
    } seq_state_t;

    localparam seq_state_t STATE_RESET = '{
        mode:       MODE_OFF,
        armed:      1'b1,
        mode_timer: 16'd0,
        both_step:  STEP_RELAY,
        one_step:   STEP_RELAY,
        two_step:   STEP_RELAY,
        tmr_both:   16'd0,
        tmr_one:    16'd0,
        tmr_two:    16'd0,
        regulate:   2'd0
    };

endpackage

FILE: src/dual_led_channel_startup_sequencer.sv
// Dual LED channel startup sequencer: one control tick per item, one result per
// tick. Throughput is one item per clock while the sink does not stall. Items pass
// the input register, then the result register, where the sequencer state is
// updated as they pass. The result register holds a finished item while the sink
// stalls and the input register still takes one more item. Write configuration
// only while idle. Depends on dlcss_pkg, dlcss_step and the assertion header.
`include "dual_led_channel_startup_sequencer_assert.svh"

module dual_led_channel_startup_sequencer
    import dlcss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_en,
    input  logic [CFG_IDX_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // level_one[7:0], level_two[15:8], elapsed_ms[25:16], upgrade_active[26],
    // overtemp_shutdown[27], fault_one[28], fault_two[29], zero[31:30]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // protection_code[1:0], all_off[2], ch1_off[3], ch2_off[4], pfc_on[5],
    // relay1_on[6], relay2_on[7], driver1_on[8], driver2_on[9], mode[12:10],
    // regulate_mask[14:13], zero[15]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    result_t    res_next;
    logic       advance;

    // Item moves from input register to result register
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, out_res_reg};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_en)
        begin
            unique case (cfg_addr)
                CFG_SYSTEM_ENABLED:  cfg_reg.system_enabled  <= cfg_data[0];
                CFG_PFC_SETTLE_MS:   cfg_reg.pfc_settle_ms   <= cfg_data;
                CFG_DRIVER_DELAY_MS: cfg_reg.driver_delay_ms <= cfg_data;
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_item_reg <= item_t'(s_axis_tdata[ITEM_W-1:0]);
    end

    // Tick evaluation
    dlcss_step u_step (
        .cfg        (cfg_reg),
        .item       (in_item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .res_next   (res_next)
    );

    // Sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res_next;
    end

    // Checks
    `DLCSS_ASSERT(a_advance_fills_output, advance |=> out_valid_reg)
    `DLCSS_ASSERT(a_state_holds_when_idle, !advance |=> $stable(state_reg))
    `DLCSS_ASSERT(a_arm_clears_into_settle, $fell(state_reg.armed) |-> state_reg.mode == MODE_SETTLE)
    `DLCSS_ASSERT_NEVER(a_stall_with_space, in_valid_reg && !out_valid_reg && !advance)

endmodule

FILE: src/dlcss_step.sv
// Per-tick protection check and startup sequencer, pure combinational.
// Depends on dlcss_pkg; instantiated by the top level.
module dlcss_step
    import dlcss_pkg::*;
(
    input  cfg_t       cfg,
    input  item_t      item,
    input  seq_state_t state_cur,
    output seq_state_t state_next,
    output result_t    res_next
);

    // Outcome of one step of a startup path
    typedef struct packed {
        step_t       step;
        logic [15:0] timer;
        logic        relay;
        logic        driver;
        logic        set_mask;
    } path_t;

    function automatic logic [15:0] sat_add(logic [15:0] t, logic [9:0] d);
        logic [16:0] sum;
        begin
            sum = {1'b0, t} + {7'd0, d};
            sat_add = sum[16] ? TIMER_MAX : sum[15:0];
        end
    endfunction

    // Relays, then drivers after the delay, then regulation
    function automatic path_t path_advance(step_t step, logic [15:0] timer,
                                           logic [15:0] delay);
        path_t p;
        begin
            p = '{step: step, timer: timer, relay: 1'b0, driver: 1'b0,
                  set_mask: 1'b0};
            unique case (step)
                STEP_RELAY:
                begin
                    p.relay = 1'b1;
                    p.timer = 16'd0;
                    p.step  = STEP_DRIVER;
                end
                STEP_DRIVER:
                begin
                    if (timer > delay)
                    begin
                        p.driver = 1'b1;
                        p.timer  = 16'd0;
                        p.step   = STEP_REGULATE;
                    end
                end
                STEP_REGULATE:
                begin
                    p.set_mask = 1'b1;
                end
                default:
                begin
                    p.step = step;
                end
            endcase
            path_advance = p;
        end
    endfunction

    logic  on1;
    logic  on2;
    logic  zero1;
    logic  zero2;
    logic  sel_both;
    logic  sel_one;
    logic  sel_two;
    prot_t code;
    path_t path;

    assign on1      = item.level_one > 8'd1;
    assign on2      = item.level_two > 8'd1;
    assign zero1    = item.level_one == 8'd0;
    assign zero2    = item.level_two == 8'd0;
    assign sel_both = on1 && on2;
    assign sel_one  = on1 && zero2;
    assign sel_two  = zero1 && on2;

    // Protection priority: all off, then channel one, then channel two
    always_comb
    begin
        priority if (!cfg.system_enabled || item.upgrade_active ||
                     item.overtemp_shutdown || (zero1 && zero2))
            code = PROT_ALL_OFF;
        else if (item.fault_one)
            code = PROT_CH1_FAULT;
        else if (item.fault_two)
            code = PROT_CH2_FAULT;
        else
            code = PROT_NONE;
    end

    // Timers, sequencer and result for this tick
    always_comb
    begin
        state_next = state_cur;
        res_next   = '0;
        path       = '{step: STEP_RELAY, timer: 16'd0, relay: 1'b0, driver: 1'b0,
                       set_mask: 1'b0};

        // Timers advance on every tick
        state_next.mode_timer = sat_add(state_cur.mode_timer, item.elapsed_ms);
        state_next.tmr_both   = sat_add(state_cur.tmr_both, item.elapsed_ms);
        state_next.tmr_one    = sat_add(state_cur.tmr_one, item.elapsed_ms);
        state_next.tmr_two    = sat_add(state_cur.tmr_two, item.elapsed_ms);

        res_next.protection_code = code;

        if (code == PROT_ALL_OFF)
        begin
            res_next.all_off = 1'b1;
        end
        else
        begin
            res_next.ch1_off = (code == PROT_CH1_FAULT) && on1;
            res_next.ch2_off = (code == PROT_CH2_FAULT) && on2;

            // One-shot power-factor start
            if ((on1 || on2) && state_cur.armed)
            begin
                state_next.mode_timer = 16'd0;
                state_next.mode       = MODE_SETTLE;
                state_next.armed      = 1'b0;
            end

            unique case (state_next.mode)
                MODE_SETTLE:
                begin
                    res_next.pfc_on = 1'b1;
                    if (state_next.mode_timer > cfg.pfc_settle_ms)
                    begin
                        if (sel_both)
                        begin
                            state_next.mode      = MODE_BOTH;
                            state_next.both_step = STEP_RELAY;
                        end
                        if (sel_one)
                        begin
                            state_next.mode     = MODE_CH1;
                            state_next.one_step = STEP_RELAY;
                        end
                        if (sel_two)
                        begin
                            state_next.mode     = MODE_CH2;
                            state_next.two_step = STEP_RELAY;
                        end
                        state_next.mode_timer = 16'd0;
                    end
                end
                MODE_BOTH:
                begin
                    path = path_advance(state_next.both_step, state_next.tmr_both,
                                        cfg.driver_delay_ms);
                    state_next.both_step = path.step;
                    state_next.tmr_both  = path.timer;
                    res_next.relay1_on   = path.relay;
                    res_next.relay2_on   = path.relay;
                    res_next.driver1_on  = path.driver;
                    res_next.driver2_on  = path.driver;
                    if (path.set_mask)
                        state_next.regulate = 2'b11;
                    if (sel_one)
                    begin
                        res_next.ch2_off    = 1'b1;
                        state_next.mode     = MODE_CH1;
                        state_next.one_step = STEP_RELAY;
                    end
                    if (sel_two)
                    begin
                        res_next.ch1_off    = 1'b1;
                        state_next.mode     = MODE_CH2;
                        state_next.two_step = STEP_RELAY;
                    end
                end
                MODE_CH1:
                begin
                    path = path_advance(state_next.one_step, state_next.tmr_one,
                                        cfg.driver_delay_ms);
                    state_next.one_step = path.step;
                    state_next.tmr_one  = path.timer;
                    res_next.relay1_on  = path.relay;
                    res_next.driver1_on = path.driver;
                    if (path.set_mask)
                        state_next.regulate = 2'b01;
                    if (sel_both)
                    begin
                        state_next.mode      = MODE_BOTH;
                        state_next.both_step = STEP_RELAY;
                    end
                    if (sel_two)
                    begin
                        res_next.ch1_off    = 1'b1;
                        state_next.mode     = MODE_CH2;
                        state_next.two_step = STEP_RELAY;
                    end
                end
                MODE_CH2:
                begin
                    path = path_advance(state_next.two_step, state_next.tmr_two,
                                        cfg.driver_delay_ms);
                    state_next.two_step = path.step;
                    state_next.tmr_two  = path.timer;
                    res_next.relay2_on  = path.relay;
                    res_next.driver2_on = path.driver;
                    if (path.set_mask)
                        state_next.regulate = 2'b10;
                    if (sel_both)
                    begin
                        state_next.mode      = MODE_BOTH;
                        state_next.both_step = STEP_RELAY;
                    end
                    if (sel_one)
                    begin
                        res_next.ch2_off    = 1'b1;
                        state_next.mode     = MODE_CH1;
                        state_next.one_step = STEP_RELAY;
                    end
                end
                default:
                begin
                    // off and unused codes do nothing
                    res_next.pfc_on = 1'b0;
                end
            endcase

            res_next.regulate_mask = state_next.regulate;
        end

        res_next.mode = state_next.mode;
    end

endmodule
